// File: design/cssr_pkg.sv
// Shared types, widths and constants for the charger start sequencer.
// No dependencies; every other file of the block imports it.
package cssr_pkg;

    // Field widths
    localparam int DUTY_W   = 8;
    localparam int VOLTS_W  = 9;
    localparam int Q4_W     = 14;
    localparam int POWER_W  = 16;
    localparam int LIM_W    = 10;
    localparam int REQ_W    = 9;
    localparam int FRAME_W  = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    // Counter widths
    localparam int WAKE_W  = 5;
    localparam int LDLY_W  = 3;
    localparam int SHUT_W  = 5;
    localparam int STEP_W  = 7;

    // Divider widths: numerator up to power * 320, denominator up to 14 bits
    localparam int DIV_NW  = 25;
    localparam int DIV_DW  = 14;
    localparam int DIV_CW  = 5;

    // Parameter defaults
    localparam int WAKE_TICKS_DEF        = 30;
    localparam int LIMIT_DELAY_TICKS_DEF = 5;
    localparam int SHUTDOWN_TICKS_DEF    = 30;
    localparam int RAMP_STEP_DEF         = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IFACE_UNUSED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_VOLTS    = 1'b1;

    // Request types
    localparam logic REQ_STATUS = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Command byte values
    localparam logic [7:0] BYTE_WAKE_ON   = 8'h24;
    localparam logic [7:0] BYTE_CMD3_ON   = 8'h8C;
    localparam logic [7:0] BYTE_CMD4_ON   = 8'h5A;
    localparam logic [7:0] BYTE_CMD5_ON   = 8'h3C;
    localparam logic [7:0] BYTE_IDLE0     = 8'h20;
    localparam logic [7:0] BYTE_IDLE2     = 8'h60;
    localparam logic [7:0] BYTE_ACTIVE1   = 8'h08;
    localparam logic [7:0] BYTE_IDLE1     = 8'h01;

    localparam logic [REQ_W-1:0]   MAX_COUNTS   = 9'd511;
    localparam logic [7:0]         AC_LIMIT_MAX = 8'h40;
    localparam logic [Q4_W-1:0]    DC_MIN_Q4    = 14'd800;
    localparam logic [VOLTS_W-1:0] VOLTS_MIN    = 9'd100;
    localparam logic [VOLTS_W-1:0] VOLTS_DEF    = 9'd230;
    localparam logic [DUTY_W-1:0]  DUTY_MAX     = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AC_GO,
        ST_AC_WAIT,
        ST_DC_GO,
        ST_DC_WAIT,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic latch_status;
        logic latch_tick;
        logic div_start;
        logic div_sel_dc;
        logic cap_ac;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_stat;

endpackage

// File: design/charger_start_sequencer_ramp.sv
// Top level of the charger start sequencer with DC current ramp.
// Depends on cssr_pkg, cssr_ctrl, cssr_dpath (and cssr_div below it).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries two kinds of item. A
//   status item (req_type 0) stores the pilot duty and gives no result; it
//   is taken while no tick is in work. A tick item (req_type 1) gives one
//   result item: the eight-byte command frame, the active decision and the
//   ramped DC current request.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data) writes register 0,
//   interface_unused, and register 1, nominal_ac_volts; write it only idle.
//   Sequence: a tick result reaches the output register after two
//   divisions on one shared restoring divider, one quotient bit per cycle
//   over 25 bits: the AC limit (power * 4 over nominal volts) and the DC
//   target (power * 320 over DC volts), each with a start and a wait state,
//   then the update state, which waits for a free output register.
//   Throughput: one status item per cycle while no tick is in work.
//   The input stalls while a tick is in work and accepts again as soon as
//   its result sits in the output register.
//   Receiver stall: the result holds in the output register; the next
//   item may still be accepted, but its update waits until the held
//   result is taken.
//   Reset (i_rst_n low, synchronous) restores the registers and the wake
//   and limit countdowns to defaults, clears the shutdown count and valid.
module charger_start_sequencer_ramp
    import cssr_pkg::*;
#(
    parameter int WAKE_TICKS        = WAKE_TICKS_DEF,
    parameter int LIMIT_DELAY_TICKS = LIMIT_DELAY_TICKS_DEF,
    parameter int SHUTDOWN_TICKS    = SHUTDOWN_TICKS_DEF,
    parameter int RAMP_STEP         = RAMP_STEP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [DUTY_W-1:0]    i_pilot_duty,
    input  logic                 i_run_charge,
    input  logic                 i_ac_request,
    input  logic [Q4_W-1:0]      i_dc_volts_q4,
    input  logic [POWER_W-1:0]   i_power_setpoint,
    input  logic [LIM_W-1:0]     i_battery_amp_limit,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FRAME_W-1:0]   o_command_frame,
    output logic                 o_charging_active,
    output logic [REQ_W-1:0]     o_current_request
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequence acceptance, divisions and the output handshake
    cssr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // hold configuration and state, divide, and build the frame
    cssr_dpath #(
        .WAKE_TICKS        (WAKE_TICKS),
        .LIMIT_DELAY_TICKS (LIMIT_DELAY_TICKS),
        .SHUTDOWN_TICKS    (SHUTDOWN_TICKS),
        .RAMP_STEP         (RAMP_STEP)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_pilot_duty        (i_pilot_duty),
        .i_run_charge        (i_run_charge),
        .i_ac_request        (i_ac_request),
        .i_dc_volts_q4       (i_dc_volts_q4),
        .i_power_setpoint    (i_power_setpoint),
        .i_battery_amp_limit (i_battery_amp_limit),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_command_frame     (o_command_frame),
        .o_charging_active   (o_charging_active),
        .o_current_request   (o_current_request)
    );

endmodule

// File: design/cssr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cssr_pkg for its widths.
module cssr_div
    import cssr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    logic [DIV_DW:0]   r_rem, n_rem;
    logic [DIV_NW-1:0] r_quot, n_quot;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_DW:0]   w_shift;

    always_comb begin
        w_shift = {r_rem[DIV_DW-1:0], r_quot[DIV_NW-1]};
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quot = i_num;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // subtract when the shifted remainder covers the divisor
            if (w_shift >= {1'b0, r_den}) begin
                n_rem  = w_shift - {1'b0, r_den};
                n_quot = {r_quot[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: design/cssr_dpath.sv
// Datapath: configuration, sequencer state, operand latch, shared divider
// and output registers. Depends on cssr_pkg and cssr_div.
module cssr_dpath
    import cssr_pkg::*;
#(
    parameter int WAKE_TICKS        = WAKE_TICKS_DEF,
    parameter int LIMIT_DELAY_TICKS = LIMIT_DELAY_TICKS_DEF,
    parameter int SHUTDOWN_TICKS    = SHUTDOWN_TICKS_DEF,
    parameter int RAMP_STEP         = RAMP_STEP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [DUTY_W-1:0]    i_pilot_duty,
    input  logic                 i_run_charge,
    input  logic                 i_ac_request,
    input  logic [Q4_W-1:0]      i_dc_volts_q4,
    input  logic [POWER_W-1:0]   i_power_setpoint,
    input  logic [LIM_W-1:0]     i_battery_amp_limit,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [FRAME_W-1:0]   o_command_frame,
    output logic                 o_charging_active,
    output logic [REQ_W-1:0]     o_current_request
);

    localparam logic [WAKE_W-1:0] WAKE_INIT  = WAKE_W'(WAKE_TICKS);
    localparam logic [LDLY_W-1:0] LDLY_INIT  = LDLY_W'(LIMIT_DELAY_TICKS);
    localparam logic [SHUT_W-1:0] SHUT_INIT  = SHUT_W'(SHUTDOWN_TICKS);
    localparam logic [STEP_W-1:0] STEP_VAL   = STEP_W'(RAMP_STEP);

    // configuration
    logic               r_iface_unused;
    logic [VOLTS_W-1:0] r_nom_volts;

    // latched tick operands
    logic               r_run, r_acreq;
    logic [Q4_W-1:0]    r_q4;
    logic [POWER_W-1:0] r_power;
    logic [LIM_W-1:0]   r_lim;

    // sequencer state
    logic [DUTY_W-1:0]  r_duty_seen;
    logic               r_active_flag, n_active_flag;
    logic [REQ_W-1:0]   r_ramp, n_ramp;
    logic [WAKE_W-1:0]  r_wake, n_wake;
    logic [LDLY_W-1:0]  r_ldly, n_ldly;
    logic [SHUT_W-1:0]  r_shut, n_shut;
    logic [7:0]         r_cb [6];
    logic [7:0]         n_cb [6];
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [7:0]         r_ac_lim;

    // divider hookup
    logic [DIV_NW-1:0]  w_num, w_num_ac, w_num_dc;
    logic [DIV_DW-1:0]  w_den;
    logic [VOLTS_W-1:0] w_volts;
    logic               w_div_done;
    logic [DIV_NW-1:0]  w_quot;

    logic [DIV_NW-1:0]  w_cap, w_tgt_wide;
    logic [REQ_W-1:0]   w_tgt, w_diff;
    logic [7:0]         w_b2;
    logic               w_running;

    always_comb begin
        w_volts  = (r_nom_volts < VOLTS_MIN) ? VOLTS_DEF : r_nom_volts;
        w_num_ac = DIV_NW'(r_power) << 2;
        w_num_dc = (DIV_NW'(r_power) << 8) + (DIV_NW'(r_power) << 6);
        if (i_cmd.div_sel_dc) begin
            w_num = w_num_dc;
            w_den = r_q4;
        end else begin
            w_num = w_num_ac;
            w_den = DIV_DW'(w_volts);
        end
    end

    cssr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stat.div_done = w_div_done;

    // tick update, evaluated while the DC quotient sits in the divider
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_cb[k] = r_cb[k];
        end
        n_wake = r_wake;
        n_ldly = r_ldly;
        n_shut = r_shut;

        if (r_iface_unused) begin
            n_active_flag = (r_duty_seen != '0) && (r_duty_seen < DUTY_MAX) && r_acreq;
        end else begin
            n_active_flag = r_run && r_acreq;
        end

        if (n_active_flag) begin
            n_shut  = SHUT_INIT;
            n_cb[1] = BYTE_ACTIVE1;
            if (r_wake != '0) begin
                n_wake = r_wake - 1'b1;
            end
            if (n_wake == '0) begin
                n_cb[2] = BYTE_WAKE_ON;
                n_cb[3] = BYTE_CMD3_ON;
                n_cb[4] = BYTE_CMD4_ON;
                n_cb[5] = BYTE_CMD5_ON;
                if (r_ldly != '0) begin
                    n_ldly = r_ldly - 1'b1;
                end
                if (n_ldly == '0) begin
                    n_cb[0] = r_ac_lim;
                end
            end
        end else begin
            n_wake  = WAKE_INIT;
            n_ldly  = LDLY_INIT;
            n_cb[0] = BYTE_IDLE0;
            n_cb[1] = BYTE_IDLE1;
            n_cb[2] = BYTE_IDLE2;
            n_cb[3] = '0;
            n_cb[4] = '0;
            n_cb[5] = '0;
            if (r_shut != '0) begin
                n_shut = r_shut - 1'b1;
            end
            if (n_shut == '0) begin
                n_cb[0] = '0;
                n_cb[1] = '0;
                n_cb[2] = '0;
            end
        end

        w_running = n_active_flag && (n_wake == '0) && (n_ldly == '0);

        // target: power * 320 over DC volts, zero at or below DC_MIN_Q4, capped by battery limit and full scale
        w_cap      = (DIV_NW'(r_lim) << 4) + (DIV_NW'(r_lim) << 2);
        w_tgt_wide = '0;
        if (r_q4 > DC_MIN_Q4) begin
            w_tgt_wide = (w_quot > w_cap) ? w_cap : w_quot;
        end
        w_tgt = (w_tgt_wide > DIV_NW'(MAX_COUNTS)) ? MAX_COUNTS : w_tgt_wide[REQ_W-1:0];

        n_ramp = r_ramp;
        w_diff = '0;
        if (w_tgt > r_ramp) begin
            w_diff = w_tgt - r_ramp;
            n_ramp = r_ramp + ((w_diff < REQ_W'(STEP_VAL)) ? w_diff : REQ_W'(STEP_VAL));
        end else if (w_tgt < r_ramp) begin
            w_diff = r_ramp - w_tgt;
            n_ramp = r_ramp - ((w_diff < REQ_W'(STEP_VAL)) ? w_diff : REQ_W'(STEP_VAL));
        end
        if (!w_running) begin
            n_ramp = '0;
        end

        // wake byte carries the request's top bit
        w_b2 = n_cb[2];
        if (n_cb[2] == BYTE_WAKE_ON) begin
            w_b2 = {BYTE_WAKE_ON[7:1], n_ramp[8]};
        end
        n_frame = {n_cb[5], n_cb[4], n_cb[3], 8'h00, n_ramp[7:0], w_b2, n_cb[1], n_cb[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iface_unused <= 1'b1;
            r_nom_volts    <= VOLTS_DEF;
            r_duty_seen    <= '0;
            r_active_flag  <= 1'b0;
            r_ramp         <= '0;
            r_wake         <= WAKE_INIT;
            r_ldly         <= LDLY_INIT;
            r_shut         <= '0;
            for (int k = 0; k < 6; k++) begin
                r_cb[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IFACE_UNUSED: r_iface_unused <= i_cfg_data[0];
                    CFG_NOM_VOLTS:    r_nom_volts    <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (i_cmd.latch_status) begin
                r_duty_seen <= i_pilot_duty;
            end
            if (i_cmd.update) begin
                r_active_flag <= n_active_flag;
                r_ramp        <= n_ramp;
                r_wake        <= n_wake;
                r_ldly        <= n_ldly;
                r_shut        <= n_shut;
                for (int k = 0; k < 6; k++) begin
                    r_cb[k] <= n_cb[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_tick) begin
            r_run   <= i_run_charge;
            r_acreq <= i_ac_request;
            r_q4    <= i_dc_volts_q4;
            r_power <= i_power_setpoint;
            r_lim   <= i_battery_amp_limit;
        end
        if (i_cmd.cap_ac) begin
            r_ac_lim <= (w_quot > DIV_NW'(AC_LIMIT_MAX)) ? AC_LIMIT_MAX : w_quot[7:0];
        end
        if (i_cmd.update) begin
            r_frame <= n_frame;
        end
    end

    assign o_command_frame   = r_frame;
    assign o_charging_active = r_active_flag;
    assign o_current_request = r_ramp;

endmodule

// File: design/cssr_ctrl.sv
// Controller: input acceptance, divider sequencing and output valid.
// Depends on cssr_pkg for its state and command types.
module cssr_ctrl
    import cssr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_req_type,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall,
    output logic     o_out_valid
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_stall  = 1'b1;

        // drop valid once the waiting item is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_req_type == REQ_TICK) begin
                        o_cmd.latch_tick = 1'b1;
                        n_state          = ST_AC_GO;
                    end else begin
                        o_cmd.latch_status = 1'b1;
                    end
                end
            end
            ST_AC_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_AC_WAIT;
            end
            ST_AC_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_ac = 1'b1;
                    n_state      = ST_DC_GO;
                end
            end
            ST_DC_GO: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_sel_dc = 1'b1;
                n_state          = ST_DC_WAIT;
            end
            ST_DC_WAIT: begin
                o_cmd.div_sel_dc = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.div_sel_dc = 1'b1;
                // hold until the output register is free
                if (w_slot_free) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: verif/cssr_checker.sv
// Checker for the charger start sequencer: watches both item channels and
// the config port, predicts each tick's command frame, compares results.
// Depends on cssr_pkg only.
module cssr_checker
    import cssr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_req_type,
    input  logic [DUTY_W-1:0]  i_pilot_duty,
    input  logic               i_run_charge,
    input  logic               i_ac_request,
    input  logic [Q4_W-1:0]    i_dc_volts_q4,
    input  logic [POWER_W-1:0] i_power_setpoint,
    input  logic [LIM_W-1:0]   i_battery_amp_limit,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [FRAME_W-1:0] i_command_frame,
    input  logic               i_charging_active,
    input  logic [REQ_W-1:0]   i_current_request,
    output int                 o_pending,
    output int                 o_mismatches
);

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               active;
        logic [REQ_W-1:0]   request;
    } t_cmd_result;

    // Shadow of the configuration registers
    logic               iface_unused_q;
    logic [VOLTS_W-1:0] nom_volts_q;

    // Shadow of the sequencer state
    logic [DUTY_W-1:0]  duty_q;
    logic               charging_q;
    logic [REQ_W-1:0]   ramp_q;
    logic [WAKE_W-1:0]  wake_left;
    logic [LDLY_W-1:0]  delay_left;
    logic [SHUT_W-1:0]  shutdown_left;
    logic [7:0]         frame_byte [6];

    t_cmd_result frames_due [$];
    int          mismatch_cnt = 0;

    // AC limit in amps: power * 4 over nominal volts, capped
    function automatic logic [7:0] ac_limit_amps(input logic [POWER_W-1:0] pw);
        int unsigned volts;
        int unsigned amps;
        volts = (nom_volts_q < VOLTS_MIN) ? 32'(VOLTS_DEF) : 32'(nom_volts_q);
        amps  = (32'(pw) * 32'd4) / volts;
        return (amps > 32'(AC_LIMIT_MAX)) ? AC_LIMIT_MAX : 8'(amps);
    endfunction

    // Step the sequencer by one tick and return the frame it sends
    function automatic t_cmd_result advance_sequencer(
        input logic               run,
        input logic               ac,
        input logic [Q4_W-1:0]    q4,
        input logic [POWER_W-1:0] pw,
        input logic [LIM_W-1:0]   lim
    );
        t_cmd_result res;
        logic [REQ_W-1:0] req;
        logic [7:0]       b2;
        int unsigned      target;
        int unsigned      cap;
        int unsigned      ramp;
        int unsigned      gap;

        req = '0;
        if (iface_unused_q)
            charging_q = (duty_q != '0) && (duty_q < DUTY_MAX) && ac;
        else
            charging_q = run && ac;

        if (charging_q) begin
            shutdown_left = SHUT_W'(SHUTDOWN_TICKS_DEF);
            frame_byte[1] = BYTE_ACTIVE1;
            if (wake_left != '0)
                wake_left = wake_left - 1'b1;
            if (wake_left == '0) begin
                frame_byte[2] = BYTE_WAKE_ON;
                frame_byte[3] = BYTE_CMD3_ON;
                frame_byte[4] = BYTE_CMD4_ON;
                frame_byte[5] = BYTE_CMD5_ON;
                if (delay_left != '0)
                    delay_left = delay_left - 1'b1;
                if (delay_left == '0)
                    frame_byte[0] = ac_limit_amps(pw);
            end
        end else begin
            wake_left     = WAKE_W'(WAKE_TICKS_DEF);
            delay_left    = LDLY_W'(LIMIT_DELAY_TICKS_DEF);
            frame_byte[0] = BYTE_IDLE0;
            frame_byte[1] = BYTE_IDLE1;
            frame_byte[2] = BYTE_IDLE2;
            frame_byte[3] = 8'h00;
            frame_byte[4] = 8'h00;
            frame_byte[5] = 8'h00;
            if (shutdown_left != '0)
                shutdown_left = shutdown_left - 1'b1;
            if (shutdown_left == '0) begin
                frame_byte[0] = 8'h00;
                frame_byte[1] = 8'h00;
                frame_byte[2] = 8'h00;
            end
        end

        if (charging_q && wake_left == '0 && delay_left == '0) begin
            // DC target only above 50 V, capped by battery limit and 511
            target = 0;
            if (q4 > DC_MIN_Q4) begin
                target = (32'(pw) * 32'd320) / 32'(q4);
                cap    = 32'(lim) * 32'd20;
                if (target > cap)
                    target = cap;
            end
            if (target > 32'(MAX_COUNTS))
                target = 32'(MAX_COUNTS);
            ramp = 32'(ramp_q);
            if (target > ramp) begin
                gap  = target - ramp;
                ramp = ramp + ((gap < RAMP_STEP_DEF) ? gap : RAMP_STEP_DEF);
            end else if (target < ramp) begin
                gap  = ramp - target;
                ramp = ramp - ((gap < RAMP_STEP_DEF) ? gap : RAMP_STEP_DEF);
            end
            ramp_q = REQ_W'(ramp);
            req    = ramp_q;
        end else begin
            ramp_q = '0;
        end

        b2 = frame_byte[2];
        if (b2 == BYTE_WAKE_ON)
            b2 = BYTE_WAKE_ON | {7'd0, req[8]};

        res.frame   = {frame_byte[5], frame_byte[4], frame_byte[3], 8'h00,
                       req[7:0], b2, frame_byte[1], frame_byte[0]};
        res.active  = charging_q;
        res.request = req;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cmd_result want;
        if (!i_rst_n) begin
            iface_unused_q = 1'b1;
            nom_volts_q    = VOLTS_DEF;
            duty_q         = '0;
            charging_q     = 1'b0;
            ramp_q         = '0;
            wake_left      = WAKE_W'(WAKE_TICKS_DEF);
            delay_left     = LDLY_W'(LIMIT_DELAY_TICKS_DEF);
            shutdown_left  = '0;
            for (int k = 0; k < 6; k++)
                frame_byte[k] = 8'h00;
            frames_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IFACE_UNUSED: iface_unused_q = i_cfg_data[0];
                    CFG_NOM_VOLTS:    nom_volts_q    = i_cfg_data[VOLTS_W-1:0];
                    default: ;
                endcase
            end

            // Compare a taken result against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    $error("command_frame: no tick pending, got %h", i_command_frame);
                    mismatch_cnt++;
                end else begin
                    want = frames_due.pop_front();
                    if (i_command_frame !== want.frame) begin
                        $error("command_frame: expected %h, got %h",
                               want.frame, i_command_frame);
                        mismatch_cnt++;
                    end
                    if (i_charging_active !== want.active) begin
                        $error("charging_active: expected %0d, got %0d",
                               want.active, i_charging_active);
                        mismatch_cnt++;
                    end
                    if (i_current_request !== want.request) begin
                        $error("current_request: expected %0d, got %0d",
                               want.request, i_current_request);
                        mismatch_cnt++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_STATUS)
                    duty_q = i_pilot_duty;
                else
                    frames_due.push_back(advance_sequencer(i_run_charge, i_ac_request,
                        i_dc_volts_q4, i_power_setpoint, i_battery_amp_limit));
            end
        end
        o_pending    <= frames_due.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// File: verif/charger_start_sequencer_ramp_tb.sv
// Testbench top for charger_start_sequencer_ramp: drives status and tick
// items, config writes and output stalls, and gives the verdict.
// Depends on cssr_pkg, cssr_checker and the block itself.
module charger_start_sequencer_ramp_tb;
    import cssr_pkg::*;

    // Margin after the last result before config writes and the end
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic               req_type;
        logic [DUTY_W-1:0]  duty;
        logic               run;
        logic               ac;
        logic [Q4_W-1:0]    q4;
        logic [POWER_W-1:0] pw;
        logic [LIM_W-1:0]   lim;
    } t_stim;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IFACE_UNUSED;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_STATUS;
    logic [DUTY_W-1:0]    pilot_duty = '0;
    logic                 run_charge = 1'b0;
    logic                 ac_request = 1'b0;
    logic [Q4_W-1:0]      dc_volts_q4 = '0;
    logic [POWER_W-1:0]   power_setpoint = '0;
    logic [LIM_W-1:0]     battery_amp_limit = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [FRAME_W-1:0]   command_frame;
    logic                 charging_active;
    logic [REQ_W-1:0]     current_request;

    int pending;
    int mismatches;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int cycle_cnt = 0;

    // Long receiver hold: the main process flips hold_kick, the stall
    // process notices the change and counts the hold out by itself.
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    charger_start_sequencer_ramp u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_req_type          (req_type),
        .i_pilot_duty        (pilot_duty),
        .i_run_charge        (run_charge),
        .i_ac_request        (ac_request),
        .i_dc_volts_q4       (dc_volts_q4),
        .i_power_setpoint    (power_setpoint),
        .i_battery_amp_limit (battery_amp_limit),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_command_frame     (command_frame),
        .o_charging_active   (charging_active),
        .o_current_request   (current_request)
    );

    cssr_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_req_type          (req_type),
        .i_pilot_duty        (pilot_duty),
        .i_run_charge        (run_charge),
        .i_ac_request        (ac_request),
        .i_dc_volts_q4       (dc_volts_q4),
        .i_power_setpoint    (power_setpoint),
        .i_battery_amp_limit (battery_amp_limit),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_command_frame     (command_frame),
        .i_charging_active   (charging_active),
        .i_current_request   (current_request),
        .o_pending           (pending),
        .o_mismatches        (mismatches)
    );

    // Guard against a hung block
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("charger_start_sequencer_ramp_tb: errors");
            $finish;
        end
    end

    // Receiver: hold off for a long stretch when kicked, else stall at random
    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Field generators: DC volts low, around the 50 V threshold, fully random, and typical
    function automatic logic [Q4_W-1:0] rand_q4();
        case ($urandom_range(9))
            0, 1:    return Q4_W'($urandom_range(0, 800));
            2:       return Q4_W'($urandom_range(790, 810));
            3, 4:    return Q4_W'($urandom);
            default: return Q4_W'($urandom_range(1600, 9600));
        endcase
    endfunction

    // Low power often keeps the AC limit below its cap
    function automatic logic [POWER_W-1:0] rand_power();
        if ($urandom_range(9) < 4)
            return POWER_W'($urandom_range(0, 4000));
        return POWER_W'($urandom);
    endfunction

    // Small limits make the battery cap bite
    function automatic logic [LIM_W-1:0] rand_limit();
        if ($urandom_range(1) == 0)
            return LIM_W'($urandom_range(0, 30));
        return LIM_W'($urandom);
    endfunction

    // Offer one item; optionally idle first. Valid stays high after the
    // handshake so the next item can follow in the very next cycle.
    task automatic send_item(input t_stim it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_type          <= it.req_type;
        pilot_duty        <= it.duty;
        run_charge        <= it.run;
        ac_request        <= it.ac;
        dc_volts_q4       <= it.q4;
        power_setpoint    <= it.pw;
        battery_amp_limit <= it.lim;
        in_valid          <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic status_item(input logic [DUTY_W-1:0] duty);
        t_stim it;
        it          = t_stim'({$urandom, $urandom});
        it.req_type = REQ_STATUS;
        it.duty     = duty;
        send_item(it);
    endtask

    task automatic tick_item(input logic run, input logic ac, input logic [Q4_W-1:0] q4,
                             input logic [POWER_W-1:0] pw, input logic [LIM_W-1:0] lim);
        t_stim it;
        it.req_type = REQ_TICK;
        it.duty     = DUTY_W'($urandom);
        it.run      = run;
        it.ac       = ac;
        it.q4       = q4;
        it.pw       = pw;
        it.lim      = lim;
        send_item(it);
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; call only while drained
    task automatic set_config(input logic iface, input logic [VOLTS_W-1:0] volts);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IFACE_UNUSED;
        cfg_data  <= CFG_DAT_W'(iface);
        @(posedge clk);
        cfg_index <= CFG_NOM_VOLTS;
        cfg_data  <= CFG_DAT_W'(volts);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1:       begin send_idle_pct = 70; recv_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct <= 70; end
            default: begin send_idle_pct = 7;  recv_stall_pct <= 7;  end
        endcase
    endtask

    // One charging session: valid pilot, a long run of active ticks so the
    // wake and limit delays can expire and the ramp move, then a stop that may
    // run the shutdown countdown out. Occasional breaks in the middle.
    task automatic charge_session();
        logic [Q4_W-1:0]    q4;
        logic [POWER_W-1:0] pw;
        logic [LIM_W-1:0]   lim;
        logic               run;
        logic               ac;
        int                 n_on;
        int                 n_off;
        q4    = rand_q4();
        pw    = rand_power();
        lim   = rand_limit();
        n_on  = $urandom_range(20, 90);
        n_off = $urandom_range(0, 40);
        status_item(DUTY_W'($urandom_range(1, 99)));
        repeat (n_on) begin
            if ($urandom_range(99) < 3) begin
                if ($urandom_range(3) == 0)
                    status_item($urandom_range(1) ? DUTY_W'($urandom_range(100, 255)) : '0);
                else
                    status_item(DUTY_W'($urandom_range(1, 99)));
            end
            if ($urandom_range(9) == 0) q4  = rand_q4();
            if ($urandom_range(9) == 0) pw  = rand_power();
            if ($urandom_range(9) == 0) lim = rand_limit();
            run = 1'b1;
            ac  = 1'b1;
            if ($urandom_range(99) < 2) begin
                run = 1'($urandom);
                ac  = 1'($urandom);
            end
            tick_item(run, ac, q4, pw, lim);
        end
        repeat (n_off) tick_item(1'($urandom), 1'b0, rand_q4(), rand_power(), rand_limit());
    endtask

    // Fully random items, both kinds
    task automatic noise_burst();
        repeat ($urandom_range(1, 5)) send_item(t_stim'({$urandom, $urandom}));
    endtask

    initial begin
        int phase_goal;
        phase_goal = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_config(1'b1, VOLTS_DEF);
        set_idling(0);

        // Directed: pilot duty edges with the interface unused
        tick_item(1'b0, 1'b0, '0, '0, '0);
        status_item(8'd0);
        tick_item(1'b1, 1'b1, 14'd16383, 16'hFFFF, 10'd1023);
        status_item(8'd100);
        tick_item(1'b1, 1'b1, 14'd16383, 16'hFFFF, 10'd1023);
        status_item(8'd255);
        tick_item(1'b1, 1'b1, 14'd800, 16'hFFFF, 10'd1023);
        status_item(8'd99);
        tick_item(1'b1, 1'b1, 14'd801, 16'hFFFF, 10'd1023);
        status_item(8'd1);
        tick_item(1'b0, 1'b1, 14'd800, '0, '0);
        // Drop the AC request: shutdown countdown starts
        tick_item(1'b1, 1'b0, 14'd16383, '0, 10'd1023);
        tick_item(1'b1, 1'b1, '0, 16'hFFFF, '0);
        drain_results();

        // Directed: run flag gates charging once an interface is present
        set_config(1'b0, 9'd99);
        tick_item(1'b0, 1'b0, 14'd6400, 16'd10000, 10'd50);
        tick_item(1'b0, 1'b1, 14'd6400, 16'd10000, 10'd50);
        tick_item(1'b1, 1'b0, 14'd6400, 16'd10000, 10'd50);
        tick_item(1'b1, 1'b1, 14'd6400, 16'd10000, 10'd50);
        status_item(8'd0);
        tick_item(1'b1, 1'b1, 14'd6400, 16'd10000, 10'd50);

        // Random phases, each with its own config and one of four idling patterns
        for (int phase = 0; phase < 7; phase++) begin
            drain_results();
            case (phase)
                0:       set_config(1'b1, VOLTS_DEF);
                1:       set_config(1'b0, 9'd500);
                2:       set_config(1'b1, 9'd0);
                3:       set_config(1'b0, 9'd99);
                4:       set_config(1'b1, VOLTS_MIN);
                5:       set_config(1'b0, 9'd511);
                default: set_config(1'b1, VOLTS_W'($urandom));
            endcase
            set_idling(phase % 4);
            // Hold the receiver off while items keep coming so the block backs up
            if (phase == 0)
                hold_kick <= ~hold_kick;
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                if ($urandom_range(3) == 0)
                    noise_burst();
                else
                    charge_session();
                // Pause until every result is back, then go on without a write
                if (phase == 2 && items_sent >= phase_goal - PHASE_ITEMS / 2
                    && items_sent < phase_goal - PHASE_ITEMS / 2 + 90)
                    drain_results();
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("charger_start_sequencer_ramp_tb: clean");
        else
            $display("charger_start_sequencer_ramp_tb: errors");
        $finish;
    end

endmodule
